FILE: rtl/met_pkg.sv
// ----------------------------------------------------------------------------
// met_pkg: shared types and constants of the Mandelbrot escape-time core
// Transaction payload structs, fixed-point widths, register indexes and the
// escape threshold used by the core and its arithmetic units.
// ----------------------------------------------------------------------------
package met_pkg;

  // Pixel index handling
  localparam int COL_W            = 12;
  localparam int PIXEL_INDEX_BITS = 12;
  // Index bits that actually take part in the mapping
  localparam int IDX_USED = (PIXEL_INDEX_BITS < COL_W) ? PIXEL_INDEX_BITS : COL_W;
  localparam int ODD_W    = IDX_USED + 1;          // 2*index+1
  localparam int PITCH_W  = 31;                    // unsigned Q3.28
  localparam int ORIGIN_W = 32;                    // signed Q4.28
  localparam int OFF_W    = ODD_W + PITCH_W;       // (2*index+1)*pitch
  localparam int OFF_SH   = 11;                    // pitch/2 moved to Q.40
  localparam int ORG_SH   = 12;                    // Q4.28 -> Q.40
  // Mapping sum: |off<<11| < 2^55, |origin<<12| <= 2^43, so 57 bits signed hold it
  localparam int MAP_W    = 57;

  // Iteration datapath
  localparam int C_W    = 56;   // c in signed Q16.40
  localparam int Z_W    = 60;   // z before the magnitude check, wide enough for 2xy + c
  localparam int MUL_W  = 48;   // operand magnitudes of the squaring unit
  localparam int HALF_W = 24;   // partial product operand width
  localparam int PROD_W = 2 * MUL_W;
  localparam int FRAC_B = 40;   // fraction bits of Q16.40
  localparam int SQ_W   = PROD_W - FRAC_B;   // truncated product width

  // |z|^2 escape threshold, 256^2 in Q.40
  localparam logic [SQ_W:0] ESC_THRESH = {1'b1, {SQ_W{1'b0}}};

  // Result fields
  localparam int CNT_W  = 16;
  localparam int FRAC_W = 17;

  // Configuration
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 3'd4;

  localparam logic [ORIGIN_W-1:0] ORIGIN_X_RST = 32'hE000_0000;   // -2.0
  localparam logic [ORIGIN_W-1:0] ORIGIN_Y_RST = 32'hF000_0000;   // -1.0
  localparam logic [PITCH_W-1:0]  PITCH_RST    = 31'd262144;
  localparam logic [CNT_W-1:0]    LIMIT_RST    = 16'd256;

  // Payloads
  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [COL_W-1:0] row;
  } in_t;

  typedef struct packed {
    logic [CNT_W-1:0]  iteration_count;
    logic              escaped;
    logic [FRAC_W-1:0] fraction;
  } out_t;

endpackage

FILE: rtl/met_mul.sv
// ----------------------------------------------------------------------------
// met_mul: iterative 48x48 fixed-point multiplier
// Builds the full product from four 24x24 partial products with a single
// multiplier and a registered accumulator, then returns floor(a*b / 2^40).
// ----------------------------------------------------------------------------
module met_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [met_pkg::MUL_W-1:0]    a,
  input  logic [met_pkg::MUL_W-1:0]    b,
  output logic                         done,
  output logic [met_pkg::SQ_W-1:0]     prod
);

  localparam int H = met_pkg::HALF_W;
  localparam int W = met_pkg::MUL_W;
  localparam int P = met_pkg::PROD_W;
  localparam logic [2:0] LAST_STEP = 3'd4;

  logic [W-1:0]   a_r, b_r;
  logic [W-1:0]   pp_r;
  logic [P-1:0]   acc_r;
  logic [2:0]     step_r;
  logic           busy_r;
  logic           done_r;
  logic [H-1:0]   op_a, op_b;
  logic [P-1:0]   pp_shifted;

  // Partial k: a half = k[1], b half = k[0]
  assign op_a = step_r[1] ? a_r[W-1:H] : a_r[H-1:0];
  assign op_b = step_r[0] ? b_r[W-1:H] : b_r[H-1:0];

  // Align the partial produced in the previous step
  always_comb begin
    case (step_r)
      3'd1:    pp_shifted = {{(P-W){1'b0}}, pp_r};
      3'd2,
      3'd3:    pp_shifted = {{(P-W-H){1'b0}}, pp_r, {H{1'b0}}};
      3'd4:    pp_shifted = {pp_r, {W{1'b0}}};
      default: pp_shifted = '0;
    endcase
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operands, partial product and accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (step_r != LAST_STEP) begin
        // Upper operand halves are zero: a 24x24 product at full width
        pp_r <= W'(op_a) * W'(op_b);
      end
      acc_r <= acc_r + pp_shifted;
    end
  end

  assign done = done_r;
  assign prod = acc_r[P-1:met_pkg::FRAC_B];

endmodule

FILE: rtl/met_div.sv
// ----------------------------------------------------------------------------
// met_div: iteration fraction divider
// Restoring divider, one quotient bit per cycle, giving
// floor(count * 2^16 / limit) for count <= limit.
// ----------------------------------------------------------------------------
module met_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [met_pkg::CNT_W-1:0]     count,
  input  logic [met_pkg::CNT_W-1:0]     limit,
  output logic                          done,
  output logic [met_pkg::FRAC_W-1:0]    quot
);

  localparam int CW = met_pkg::CNT_W;
  localparam int QW = met_pkg::FRAC_W;
  localparam logic [4:0] LAST_STEP = 5'(QW - 1);

  logic [CW-1:0] rem_r;
  logic [CW-1:0] div_r;
  logic [QW-1:0] q_r;
  logic          bit0_r;
  logic [4:0]    step_r;
  logic          busy_r;
  logic          done_r;
  logic          bit_in;
  logic [CW:0]   trial;
  logic          ge;
  logic [CW:0]   diff;

  // The low count bit is the only nonzero dividend bit still to come in
  assign bit_in = (step_r == 5'd0) ? bit0_r : 1'b0;
  assign trial  = {rem_r, bit_in};
  assign ge     = (trial >= {1'b0, div_r});
  assign diff   = trial - {1'b0, div_r};

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 5'd1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient; count/2 < limit, so upper quotient bits are zero
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {1'b0, count[CW-1:1]};
      bit0_r <= count[0];
      div_r  <= limit;
      q_r    <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[CW-1:0] : trial[CW-1:0];
      q_r   <= {q_r[QW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

FILE: rtl/mandelbrot_escape_time_core.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_core: Mandelbrot escape-time evaluator
// Maps a pixel to c in fixed point, iterates z = z*z + c and returns the
// iteration count, the escape flag and count/limit as a Q1.16 fraction.
// ----------------------------------------------------------------------------
// One pixel is worked on at a time; in_ready is high only while the core is
// idle. Each iteration is paced by the single 24x24 multiplier that builds
// every 48x48 product (x*x, y*y, x*y) from four partial products. A pixel
// that runs to the iteration limit passes, from acceptance to the output
// register, through taking the pixel, coordinate mapping, the overflow
// check and the squares of the start point, the iterations, the final limit
// check, the bit-serial fraction divider and loading the result. An escaping
// pixel finishes earlier. The finished result sits in an output register, so
// the next pixel can be taken while it waits for out_ready.
// Coordinates are signed Q4.28 and pitches unsigned Q3.28; z runs in
// signed Q16.40. A square that would overflow (|x| or |y| of 256 or more)
// counts as escape, and a point outside the Q16.40 range is clamped to its
// bound. A zero iteration limit returns all-zero results.
module mandelbrot_escape_time_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // Pixel input
  input  logic                               in_valid,
  output logic                               in_ready,
  input  met_pkg::in_t                       in_data,
  // Result output
  output logic                               out_valid,
  input  logic                               out_ready,
  output met_pkg::out_t                      out_data,
  // Configuration writes
  input  logic                               cfg_wr_en,
  input  logic [met_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [met_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int IU    = met_pkg::IDX_USED;
  localparam int ODD_W = met_pkg::ODD_W;
  localparam int OFF_W = met_pkg::OFF_W;
  localparam int MAP_W = met_pkg::MAP_W;
  localparam int C_W   = met_pkg::C_W;
  localparam int Z_W   = met_pkg::Z_W;
  localparam int MW    = met_pkg::MUL_W;
  localparam int SQ_W  = met_pkg::SQ_W;
  localparam int CW    = met_pkg::CNT_W;
  localparam int OW    = met_pkg::ORIGIN_W;

  typedef enum logic [4:0] {
    S_IDLE, S_MAPX, S_MAPY, S_SUMY,
    S_CHK, S_SQX, S_WSQX, S_SQY, S_WSQY,
    S_TEST, S_LOOP, S_SQXY, S_WXY, S_ADD,
    S_DIV, S_WDIV, S_OUT
  } state_t;

  // Configuration registers
  logic [OW-1:0]               origin_x_r, origin_y_r;
  logic [met_pkg::PITCH_W-1:0] pitch_x_r, pitch_y_r;
  logic [CW-1:0]               limit_r;

  // Sequencer and datapath registers
  state_t                      state_r;
  met_pkg::in_t                in_r;
  logic [OFF_W-1:0]            off_r;
  logic [C_W-1:0]              cx_r, cy_r;
  logic [Z_W-1:0]              x_r, y_r;
  logic [SQ_W-1:0]             xx_r, yy_r, xy_r;
  logic [CW-1:0]               count_r;
  logic                        esc_r;
  logic                        first_r;
  logic [met_pkg::FRAC_W-1:0]  frac_r;
  logic                        out_valid_r;
  met_pkg::out_t               out_data_r;

  // Mapping path
  logic [ODD_W-1:0]            map_odd;
  logic [met_pkg::PITCH_W-1:0] map_pitch;
  logic [OFF_W-1:0]            map_prod;
  logic [OW-1:0]               map_origin;
  logic [MAP_W-1:0]            map_sum;
  logic [C_W-1:0]              map_c;

  // Iteration path
  logic [Z_W-1:0]              ax_full, ay_full;
  logic                        big_x, big_y;
  logic [MW-1:0]               ax, ay;
  logic [Z_W-1:0]              cx_ext, cy_ext, xy2, nx, ny;
  logic [SQ_W:0]               sq_sum;

  // Arithmetic units
  logic                        mul_start, mul_done;
  logic [MW-1:0]               mul_a, mul_b;
  logic [SQ_W-1:0]             mul_prod;
  logic                        div_start, div_done;
  logic [met_pkg::FRAC_W-1:0]  div_quot;

  // Configuration write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= met_pkg::ORIGIN_X_RST;
      origin_y_r <= met_pkg::ORIGIN_Y_RST;
      pitch_x_r  <= met_pkg::PITCH_RST;
      pitch_y_r  <= met_pkg::PITCH_RST;
      limit_r    <= met_pkg::LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        met_pkg::REG_ORIGIN_X:   origin_x_r <= cfg_data[OW-1:0];
        met_pkg::REG_ORIGIN_Y:   origin_y_r <= cfg_data[OW-1:0];
        met_pkg::REG_PITCH_X:    pitch_x_r  <= cfg_data[met_pkg::PITCH_W-1:0];
        met_pkg::REG_PITCH_Y:    pitch_y_r  <= cfg_data[met_pkg::PITCH_W-1:0];
        met_pkg::REG_ITER_LIMIT: limit_r    <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // c = origin*2^12 + (2*index+1)*pitch*2^11, clamped to Q16.40
  assign map_odd    = (state_r == S_MAPY) ? {in_r.row[IU-1:0], 1'b1}
                                          : {in_r.column[IU-1:0], 1'b1};
  assign map_pitch  = (state_r == S_MAPY) ? pitch_y_r : pitch_x_r;
  assign map_prod   = OFF_W'(map_odd) * OFF_W'(map_pitch);
  assign map_origin = (state_r == S_SUMY) ? origin_y_r : origin_x_r;
  assign map_sum    = {{(MAP_W-OW-met_pkg::ORG_SH){map_origin[OW-1]}}, map_origin,
                       {met_pkg::ORG_SH{1'b0}}}
                    + {{(MAP_W-OFF_W-met_pkg::OFF_SH){1'b0}}, off_r,
                       {met_pkg::OFF_SH{1'b0}}};

  always_comb begin
    if (!map_sum[MAP_W-1] && map_sum[C_W-1]) begin
      map_c = {1'b0, {(C_W-1){1'b1}}};
    end else if (map_sum[MAP_W-1] && !map_sum[C_W-1]) begin
      map_c = {1'b1, {(C_W-1){1'b0}}};
    end else begin
      map_c = map_sum[C_W-1:0];
    end
  end

  // Magnitudes and the square overflow check
  assign ax_full = x_r[Z_W-1] ? (Z_W'(0) - x_r) : x_r;
  assign ay_full = y_r[Z_W-1] ? (Z_W'(0) - y_r) : y_r;
  assign big_x   = |ax_full[Z_W-1:MW];
  assign big_y   = |ay_full[Z_W-1:MW];
  assign ax      = ax_full[MW-1:0];
  assign ay      = ay_full[MW-1:0];

  // Next z: x' = xx - yy + cx, y' = +-2xy + cy
  assign cx_ext = {{(Z_W-C_W){cx_r[C_W-1]}}, cx_r};
  assign cy_ext = {{(Z_W-C_W){cy_r[C_W-1]}}, cy_r};
  assign xy2    = {{(Z_W-SQ_W-1){1'b0}}, xy_r, 1'b0};
  assign nx     = {{(Z_W-SQ_W){1'b0}}, xx_r} - {{(Z_W-SQ_W){1'b0}}, yy_r} + cx_ext;
  assign ny     = ((x_r[Z_W-1] ^ y_r[Z_W-1]) ? (Z_W'(0) - xy2) : xy2) + cy_ext;

  // |z|^2 for the escape test
  assign sq_sum = {1'b0, xx_r} + {1'b0, yy_r};

  // Shared multiplier operand select
  assign mul_start = (state_r == S_SQX) || (state_r == S_SQY) || (state_r == S_SQXY);
  assign mul_a     = (state_r == S_SQY) ? ay : ax;
  assign mul_b     = (state_r == S_SQX) ? ax : ay;
  assign div_start = (state_r == S_DIV);

  met_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  met_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .count (count_r),
    .limit (limit_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      esc_r       <= 1'b0;
      first_r     <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            in_r    <= in_data;
            state_r <= S_MAPX;
          end
        end
        S_MAPX: begin
          off_r   <= map_prod;
          state_r <= S_MAPY;
        end
        S_MAPY: begin
          off_r   <= map_prod;
          cx_r    <= map_c;
          x_r     <= {{(Z_W-C_W){map_c[C_W-1]}}, map_c};
          state_r <= S_SUMY;
        end
        S_SUMY: begin
          cy_r    <= map_c;
          y_r     <= {{(Z_W-C_W){map_c[C_W-1]}}, map_c};
          count_r <= '0;
          esc_r   <= 1'b0;
          first_r <= 1'b1;
          state_r <= (limit_r == '0) ? S_DIV : S_CHK;
        end
        // Square overflow counts as escape
        S_CHK: begin
          if (big_x || big_y) begin
            esc_r   <= 1'b1;
            state_r <= S_DIV;
          end else begin
            state_r <= S_SQX;
          end
        end
        S_SQX: state_r <= S_WSQX;
        S_WSQX: begin
          if (mul_done) begin
            xx_r    <= mul_prod;
            state_r <= S_SQY;
          end
        end
        S_SQY: state_r <= S_WSQY;
        // Squares of the start point feed the first iteration directly
        S_WSQY: begin
          if (mul_done) begin
            yy_r    <= mul_prod;
            first_r <= 1'b0;
            state_r <= first_r ? S_LOOP : S_TEST;
          end
        end
        // Squares of the new z serve as the escape test and the next x*x, y*y
        S_TEST: begin
          if (sq_sum > met_pkg::ESC_THRESH) begin
            esc_r   <= 1'b1;
            state_r <= S_DIV;
          end else begin
            count_r <= count_r + CW'(1);
            state_r <= S_LOOP;
          end
        end
        S_LOOP: begin
          state_r <= (count_r < limit_r) ? S_SQXY : S_DIV;
        end
        S_SQXY: state_r <= S_WXY;
        S_WXY: begin
          if (mul_done) begin
            xy_r    <= mul_prod;
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          x_r     <= nx;
          y_r     <= ny;
          state_r <= S_CHK;
        end
        S_DIV: state_r <= S_WDIV;
        S_WDIV: begin
          if (div_done) begin
            frac_r  <= (limit_r == '0) ? '0 : div_quot;
            state_r <= S_OUT;
          end
        end
        // Hand the result to the output register once it is free
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_data_r.iteration_count <= count_r;
            out_data_r.escaped         <= esc_r;
            out_data_r.fraction        <= frac_r;
            out_valid_r                <= 1'b1;
            state_r                    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: test/tb_mandelbrot_escape_time_core.sv
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_time_core: self-checking bench for the escape-time core
// Drives pixel transactions through the valid/ready input, programs views and
// iteration limits through the register port while the core is idle, and
// checks every result against a fixed-point escape-time predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_mandelbrot_escape_time_core;

  // Field widths taken from the package
  localparam int COL_W      = met_pkg::COL_W;
  localparam int PITCH_W    = met_pkg::PITCH_W;
  localparam int ORIGIN_W   = met_pkg::ORIGIN_W;
  localparam int CNT_W      = met_pkg::CNT_W;
  localparam int FRAC_W     = met_pkg::FRAC_W;
  localparam int CFG_IDX_W  = met_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = met_pkg::CFG_DATA_W;

  // Q16.40 bounds and escape limits of the iteration
  localparam longint Z_HI       = (64'sd1 <<< 55) - 1;
  localparam longint Z_LO       = -Z_HI - 1;
  localparam longint SQ_OVF     = 64'sd1 <<< 48;
  localparam longint MAG2_LIMIT = 64'sd1 <<< 56;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  met_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  met_pkg::out_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = met_pkg::REG_ORIGIN_X;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the view registers
  logic signed [ORIGIN_W-1:0] view_org_x = met_pkg::ORIGIN_X_RST;
  logic signed [ORIGIN_W-1:0] view_org_y = met_pkg::ORIGIN_Y_RST;
  logic [PITCH_W-1:0] view_pitch_x = met_pkg::PITCH_RST;
  logic [PITCH_W-1:0] view_pitch_y = met_pkg::PITCH_RST;
  logic [CNT_W-1:0] iter_limit = met_pkg::LIMIT_RST;

  met_pkg::out_t pixel_results_q[$];
  met_pkg::out_t head;
  int mismatch_count = 0;
  int pixels_sent = 0;
  int pixels_checked = 0;
  int escaped_seen = 0;
  int bounded_seen = 0;
  int views_used = 1;

  mandelbrot_escape_time_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // Escape-time predictor
  // ------------------------------------------------------------------------

  // origin + (index + 1/2) * pitch in Q16.40, clamped to the z range
  function automatic longint pixel_to_point(input logic signed [ORIGIN_W-1:0] origin,
                                            input logic [PITCH_W-1:0] pitch,
                                            input logic [COL_W-1:0] index);
    logic [COL_W-1:0] idx;
    longint odd;
    longint off;
    longint pt;
    idx = index & COL_W'((1 << met_pkg::PIXEL_INDEX_BITS) - 1);
    odd = 2 * longint'(idx) + 1;
    off = (odd * longint'(pitch)) <<< met_pkg::OFF_SH;
    pt = longint'(origin) * (64'sd1 <<< met_pkg::ORG_SH) + off;
    if (pt > Z_HI) pt = Z_HI;
    if (pt < Z_LO) pt = Z_LO;
    return pt;
  endfunction

  function automatic longint abs_q40(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Magnitude product truncated back to Q.40
  function automatic longint mul_q40(input longint a, input longint b);
    logic [127:0] pa;
    logic [127:0] pb;
    logic [127:0] p;
    pa = {64'd0, a};
    pb = {64'd0, b};
    p = pa * pb;
    return longint'(p[103:40]);
  endfunction

  function automatic met_pkg::out_t escape_time_of(input met_pkg::in_t px);
    longint cx, cy, x, y, ax, ay, xx, yy, xy, nx, ny, nax, nay, frac;
    int count;
    logic esc;
    met_pkg::out_t res;
    cx = pixel_to_point(view_org_x, view_pitch_x, px.column);
    cy = pixel_to_point(view_org_y, view_pitch_y, px.row);
    x = cx;
    y = cy;
    count = 0;
    esc = 1'b0;
    while (count < int'(iter_limit)) begin
      ax = abs_q40(x);
      ay = abs_q40(y);
      // operand too large to square
      if (ax >= SQ_OVF || ay >= SQ_OVF) begin
        esc = 1'b1;
        break;
      end
      xx = mul_q40(ax, ax);
      yy = mul_q40(ay, ay);
      xy = mul_q40(ax, ay) <<< 1;
      nx = xx - yy + cx;
      ny = (((x < 0) != (y < 0)) ? -xy : xy) + cy;
      nax = abs_q40(nx);
      nay = abs_q40(ny);
      if (nax >= SQ_OVF || nay >= SQ_OVF) begin
        esc = 1'b1;
        break;
      end
      if (mul_q40(nax, nax) + mul_q40(nay, nay) > MAG2_LIMIT) begin
        esc = 1'b1;
        break;
      end
      x = nx;
      y = ny;
      count++;
    end
    res.iteration_count = count[CNT_W-1:0];
    res.escaped = esc;
    if (iter_limit == 0) begin
      res.fraction = '0;
    end else begin
      frac = (longint'(count) <<< 16) / longint'(iter_limit);
      res.fraction = frac[FRAC_W-1:0];
    end
    return res;
  endfunction

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------

  // Mostly back-to-back, sometimes short pauses, rarely long ones
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // One pixel transaction; valid is left high so a following call can chain
  task automatic send_pixel(input logic [COL_W-1:0] col, input logic [COL_W-1:0] row);
    met_pkg::in_t px;
    int gap;
    px.column = col;
    px.row = row;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (!in_ready);
    pixel_results_q.push_back(escape_time_of(px));
    pixels_sent++;
  endtask

  task automatic send_random_pixels(input int n);
    repeat (n) send_pixel(COL_W'($urandom), COL_W'($urandom));
  endtask

  // Hold off the sender until every pending result has been taken
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pixel_results_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      met_pkg::REG_ORIGIN_X:   view_org_x = data;
      met_pkg::REG_ORIGIN_Y:   view_org_y = data;
      met_pkg::REG_PITCH_X:    view_pitch_x = data[PITCH_W-1:0];
      met_pkg::REG_PITCH_Y:    view_pitch_y = data[PITCH_W-1:0];
      met_pkg::REG_ITER_LIMIT: iter_limit = data[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_view(input logic [31:0] ox, input logic [31:0] oy,
                          input logic [PITCH_W-1:0] px, input logic [PITCH_W-1:0] py,
                          input logic [CNT_W-1:0] lim);
    write_reg(met_pkg::REG_ORIGIN_X, ox);
    write_reg(met_pkg::REG_ORIGIN_Y, oy);
    write_reg(met_pkg::REG_PITCH_X, {1'b0, px});
    write_reg(met_pkg::REG_PITCH_Y, {1'b0, py});
    write_reg(met_pkg::REG_ITER_LIMIT, {16'd0, lim});
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    views_used++;
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Reset view (x -2..2, y -1..3): corners, set interior, index bit patterns
  task automatic test_reset_view();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd2048, 12'd1024);   // c near 0, runs to the limit
    send_pixel(12'd1024, 12'd1024);   // c near -1, period-two bulb
    send_pixel(12'd2560, 12'd1536);   // c near 0.5+0.5i, escapes after a few
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);
    wait_idle();
  endtask

  // Smallest limits: one iteration gives a full-scale fraction, zero gives zeros
  task automatic test_limit_edges();
    write_reg(met_pkg::REG_ITER_LIMIT, 32'd1);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    send_pixel(12'd2048, 12'd1024);
    send_pixel(12'd0, 12'd0);
    send_random_pixels(3);
    wait_idle();
    write_reg(met_pkg::REG_ITER_LIMIT, 32'd0);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    send_pixel(12'd2048, 12'd1024);
    send_random_pixels(2);
    wait_idle();
  endtask

  // Far views at the register extremes: clamped points and overflowing squares
  task automatic test_far_views();
    set_view(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 31'd0, 16'hFFFF);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_random_pixels(3);
    wait_idle();
    set_view(32'h8000_0000, 32'h7FFF_FFFF, 31'd0, 31'h7FFF_FFFF, 16'hFFFF);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_random_pixels(3);
    wait_idle();
  endtask

  // Standard view at the default limit of 256
  task automatic test_full_depth_view();
    set_view(met_pkg::ORIGIN_X_RST, met_pkg::ORIGIN_Y_RST, met_pkg::PITCH_RST,
             met_pkg::PITCH_RST, met_pkg::LIMIT_RST);
    send_random_pixels(30);
    wait_idle();
  endtask

  // Random zoomed views near the set with short limits, plus raw register noise
  task automatic test_random_views();
    logic signed [31:0] ox, oy;
    logic [PITCH_W-1:0] px, py;
    logic [CNT_W-1:0] lim;
    for (int phase = 0; phase < 13; phase++) begin
      if ($urandom_range(0, 3) != 0) begin
        ox = $urandom_range(0, 32'h4000_0000);
        ox = ox - 32'sh3000_0000;
        oy = $urandom_range(0, 32'h3000_0000);
        oy = oy - 32'sh2000_0000;
        px = PITCH_W'($urandom_range(1 << 12, 1 << 14) << $urandom_range(0, 6));
        py = PITCH_W'($urandom_range(1 << 12, 1 << 14) << $urandom_range(0, 6));
        lim = CNT_W'($urandom_range(2, 32));
      end else begin
        ox = $urandom;
        oy = $urandom;
        px = PITCH_W'($urandom);
        py = PITCH_W'($urandom);
        lim = CNT_W'($urandom_range(1, 64));
      end
      set_view(ox, oy, px, py, lim);
      send_random_pixels(40);
      wait_idle();
    end
  endtask

  // ------------------------------------------------------------------------
  // Result sink: random back-pressure with long ready stretches
  // ------------------------------------------------------------------------
  initial begin
    int n;
    forever begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 600) : $urandom_range(1, 30);
      repeat (n) begin
        @(posedge clk);
        out_ready <= 1'b1;
      end
      n = idle_gap();
      repeat (n) begin
        @(posedge clk);
        out_ready <= 1'b0;
      end
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pixel_results_q.size() == 0) begin
        $error("result with no pixel pending: %h", out_data);
        mismatch_count++;
      end else begin
        head = pixel_results_q.pop_front();
        pixels_checked++;
        if (out_data.escaped) escaped_seen++;
        else bounded_seen++;
        if (out_data.iteration_count !== head.iteration_count) begin
          $error("iteration_count: expected %0d, got %0d",
                 head.iteration_count, out_data.iteration_count);
          mismatch_count++;
        end
        if (out_data.escaped !== head.escaped) begin
          $error("escaped: expected %0d, got %0d", head.escaped, out_data.escaped);
          mismatch_count++;
        end
        if (out_data.fraction !== head.fraction) begin
          $error("fraction: expected %0d, got %0d", head.fraction, out_data.fraction);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #50_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_view();
    test_limit_edges();
    test_far_views();
    test_full_depth_view();
    test_random_views();
    wait_idle();
    repeat (100) @(posedge clk);
    $display("Checked %0d of %0d pixels across %0d view/limit settings",
             pixels_checked, pixels_sent, views_used);
    $display("%0d pixels escaped, %0d stayed bounded; %0d field mismatches",
             escaped_seen, bounded_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
